@@ src/plb_pkg.sv @@
// Package for the positional list buffer: sizes, command and status codes,
// beat types and the control struct that drives the row of storage cells.
// No dependencies.
package plb_pkg;

  // Capacity of the list and the widths that follow from it.
  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Fixed field widths of the beats.
  localparam int CMD_W = 3;
  localparam int POS_W = 5;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;
  localparam int EC_W  = 5;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_INSERT   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DEL_END  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DUMP     = 3'd4;

  // Status codes.
  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [ST_W-1:0] ST_BADPOS = 2'd3;

  // Operations broadcast to every cell of the chain.
  typedef logic [1:0] cell_op_t;
  localparam cell_op_t OP_HOLD = 2'd0;
  localparam cell_op_t OP_INS  = 2'd1;
  localparam cell_op_t OP_DEL  = 2'd2;
  localparam cell_op_t OP_ROT  = 2'd3;

  // Control shared by all cells in one cycle.
  typedef struct packed {
    cell_op_t         op;
    logic [IDX_W-1:0] idx;   // slot that is inserted or removed
    logic [IDX_W-1:0] tail;  // last occupied slot, used by rotation
  } cell_ctl_t;

  // Command beat.
  typedef struct packed {
    logic        [CMD_W-1:0] command;
    logic        [POS_W-1:0] position;
    logic signed [VAL_W-1:0] value;
  } cmd_beat_t;

  // Result beat.
  typedef struct packed {
    logic        [ST_W-1:0]  status;
    logic signed [VAL_W-1:0] entry_value;
    logic        [EC_W-1:0]  entry_count;
    logic                    last;
  } res_beat_t;

endpackage

@@ src/positional_list_buffer_unit.sv @@
// An edit command gives its single result beat in the cycle after acceptance.
// Edits run at one command per cycle while results are taken; a dump of N
// entries blocks commands and gives one beat per cycle from the head cell
// while results are taken. Insert and delete shift the cells from their slot on.
// Reset clears the entry count and the control state; cell contents are not reset.
// Depends on plb_pkg and plb_cell.
module positional_list_buffer_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  plb_pkg::cmd_beat_t cmd_beat,
  output logic               res_valid,
  input  logic               res_ready,
  output plb_pkg::res_beat_t res_beat
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DUMP = 1'b1;

  logic                             state;
  logic                             state_next;
  logic [plb_pkg::CNT_W-1:0]        count;
  logic [plb_pkg::CNT_W-1:0]        count_next;
  logic [plb_pkg::CNT_W-1:0]        left_cnt;
  logic [plb_pkg::CNT_W-1:0]        left_cnt_next;
  logic                             res_ld;
  plb_pkg::res_beat_t               res_next;
  plb_pkg::cell_ctl_t               ctl;
  logic                             out_free;
  logic                             accept;
  logic [plb_pkg::CNT_W:0]          pos_x;
  logic [plb_pkg::CNT_W:0]          cnt_x;
  logic [plb_pkg::POS_W-1:0]        pos_m1;
  logic [plb_pkg::CNT_W-1:0]        cnt_m1;
  logic signed [plb_pkg::VAL_W-1:0] q [plb_pkg::DEPTH];

  assign out_free  = !res_valid || res_ready;
  assign cmd_ready = (state == S_IDLE) && out_free;
  assign accept    = cmd_valid && cmd_ready;
  assign pos_x     = (plb_pkg::CNT_W + 1)'(cmd_beat.position);
  assign cnt_x     = (plb_pkg::CNT_W + 1)'(count);
  assign pos_m1    = cmd_beat.position - 1'b1;
  assign cnt_m1    = count - 1'b1;

  // Command decode, chain control and result formation.
  always_comb begin
    state_next     = state;
    count_next     = count;
    left_cnt_next  = left_cnt;
    res_ld         = 1'b0;
    res_next       = '0;
    res_next.last  = 1'b1;
    ctl.op         = plb_pkg::OP_HOLD;
    ctl.idx        = pos_m1[plb_pkg::IDX_W-1:0];
    ctl.tail       = cnt_m1[plb_pkg::IDX_W-1:0];
    if (state == S_DUMP) begin
      if (out_free) begin
        res_ld               = 1'b1;
        res_next.status      = plb_pkg::ST_OK;
        res_next.entry_value = q[0];
        res_next.last        = (left_cnt == 1);
        ctl.op               = plb_pkg::OP_ROT;
        left_cnt_next        = left_cnt - 1'b1;
        if (left_cnt == 1) begin
          state_next = S_IDLE;
        end
      end
    end else if (accept) begin
      res_ld          = 1'b1;
      res_next.status = plb_pkg::ST_OK;
      unique case (cmd_beat.command)
        plb_pkg::CMD_INSERT: begin
          if (count == plb_pkg::DEPTH) begin
            res_next.status = plb_pkg::ST_FULL;
          end else if (pos_x == 0 || pos_x > cnt_x + 1'b1) begin
            res_next.status = plb_pkg::ST_BADPOS;
          end else begin
            ctl.op     = plb_pkg::OP_INS;
            count_next = count + 1'b1;
          end
        end
        plb_pkg::CMD_APPEND: begin
          if (count == plb_pkg::DEPTH) begin
            res_next.status = plb_pkg::ST_FULL;
          end else begin
            ctl.op     = plb_pkg::OP_INS;
            ctl.idx    = count[plb_pkg::IDX_W-1:0];
            count_next = count + 1'b1;
          end
        end
        plb_pkg::CMD_DELETE: begin
          if (count == 0) begin
            res_next.status = plb_pkg::ST_EMPTY;
          end else if (pos_x == 0 || pos_x > cnt_x) begin
            res_next.status = plb_pkg::ST_BADPOS;
          end else begin
            ctl.op     = plb_pkg::OP_DEL;
            count_next = cnt_m1;
          end
        end
        plb_pkg::CMD_DEL_END: begin
          if (count == 0) begin
            res_next.status = plb_pkg::ST_EMPTY;
          end else begin
            count_next = cnt_m1;
          end
        end
        plb_pkg::CMD_DUMP: begin
          if (count == 0) begin
            res_next.status = plb_pkg::ST_EMPTY;
          end else begin
            // Results come from the head cell while the chain rotates.
            res_ld        = 1'b0;
            left_cnt_next = count;
            state_next    = S_DUMP;
          end
        end
        default: begin
        end
      endcase
    end
    res_next.entry_count = plb_pkg::EC_W'(count_next);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      left_cnt  <= '0;
      res_valid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      left_cnt <= left_cnt_next;
      if (res_ld) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Result beat register.
  always_ff @(posedge clk) begin
    if (res_ld) begin
      res_beat <= res_next;
    end
  end

  // Row of storage cells, each linked to its neighbors; the end cells see zero.
  for (genvar i = 0; i < plb_pkg::DEPTH; i++) begin : g_cell
    logic signed [plb_pkg::VAL_W-1:0] nb_left;
    logic signed [plb_pkg::VAL_W-1:0] nb_right;
    if (i == 0) begin : g_first
      assign nb_left = '0;
    end else begin : g_mid_l
      assign nb_left = q[i-1];
    end
    if (i == plb_pkg::DEPTH - 1) begin : g_final
      assign nb_right = '0;
    end else begin : g_mid_r
      assign nb_right = q[i+1];
    end
    plb_cell u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .slot  (plb_pkg::IDX_W'(i)),
      .din   (cmd_beat.value),
      .left  (nb_left),
      .right (nb_right),
      .head  (q[0]),
      .q     (q[i])
    );
  end

  // The entry count never exceeds the capacity.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= plb_pkg::DEPTH)
    else $error("entry count above capacity");

  // A dump never changes the entry count.
  a_dump_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_DUMP) |=> $stable(count))
    else $error("entry count changed during dump");

  // The beat marked last of a dump returns the block to idle.
  a_dump_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_DUMP && res_ld && res_next.last) |=> (state == S_IDLE))
    else $error("dump did not end on its final beat");

  // Commands are refused while a dump is in progress.
  a_dump_block: assert property (@(posedge clk) disable iff (rst)
    (state == S_DUMP) |-> !cmd_ready)
    else $error("command accepted during dump");

endmodule

@@ src/plb_cell.sv @@
// One storage cell of the list chain: holds one entry and loads from its
// neighbors, the new value or the head of the chain on shift and rotate.
// Depends on plb_pkg.
module plb_cell (
  input  logic                             clk,
  input  plb_pkg::cell_ctl_t               ctl,
  input  logic [plb_pkg::IDX_W-1:0]        slot,
  input  logic signed [plb_pkg::VAL_W-1:0] din,
  input  logic signed [plb_pkg::VAL_W-1:0] left,
  input  logic signed [plb_pkg::VAL_W-1:0] right,
  input  logic signed [plb_pkg::VAL_W-1:0] head,
  output logic signed [plb_pkg::VAL_W-1:0] q
);

  // Insert shifts later entries right, delete pulls them left, and rotate
  // moves the whole list one place toward the head with wrap at the tail.
  always_ff @(posedge clk) begin
    unique case (ctl.op)
      plb_pkg::OP_INS: begin
        if (slot == ctl.idx) begin
          q <= din;
        end else if (slot > ctl.idx) begin
          q <= left;
        end
      end
      plb_pkg::OP_DEL: begin
        if (slot >= ctl.idx) begin
          q <= right;
        end
      end
      plb_pkg::OP_ROT: begin
        if (slot == ctl.tail) begin
          q <= head;
        end else begin
          q <= right;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
